[hw/rtl/incp_pkg.sv]
// ----------------------------------------------------------------------------
// incp_pkg
// Shared types and constants for the interrupt nesting cycle profiler.
// ----------------------------------------------------------------------------
`default_nettype none

package incp_pkg;

  localparam logic [2:0] OP_ENTER = 3'd0;
  localparam logic [2:0] OP_EXIT  = 3'd1;
  localparam logic [2:0] OP_READ  = 3'd2;
  localparam logic [2:0] OP_CLEAR = 3'd3;
  localparam logic [2:0] OP_INIT  = 3'd4;

  localparam logic [7:0] DEPTH_MAX  = 8'd255;
  localparam logic [5:0] OWNER_NONE = 6'h3F;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_UPDATE,
    S_SECOND,
    S_STAMP,
    S_OUTPUT
  } state_t;

  typedef struct packed {
    logic start;
    logic rd_first;
    logic upd_a;
    logic upd_b;
    logic stamp;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic is_enter;
    logic is_exit;
    logic prev_ok;
  } sts_t;

endpackage

`default_nettype wire

[hw/rtl/incp_ctrl.sv]
// ----------------------------------------------------------------------------
// incp_ctrl
// Sequencer: steps each request through table reads, updates and output.
// ----------------------------------------------------------------------------
`default_nettype none

module incp_ctrl (
  input  wire           clk,
  input  wire           rst,
  input  wire           in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire           out_stall,
  input  incp_pkg::sts_t sts,
  output incp_pkg::cmd_t cmd
);
  import incp_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_first = 1'b1;
        state_next   = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.upd_a = 1'b1;
        if (sts.is_enter) begin
          state_next = S_SECOND;
        end else if (sts.is_exit && sts.prev_ok) begin
          state_next = S_STAMP;
        end else begin
          state_next = S_OUTPUT;
        end
      end
      S_SECOND: begin
        cmd.upd_b  = 1'b1;
        state_next = S_OUTPUT;
      end
      S_STAMP: begin
        cmd.stamp  = 1'b1;
        state_next = S_OUTPUT;
      end
      S_OUTPUT: begin
        if (!out_valid || !out_stall) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/incp_datapath.sv]
// ----------------------------------------------------------------------------
// incp_datapath
// Nesting state, per-interrupt count, usage and stamp tables, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module incp_datapath #(
  parameter int NUM_IRQ = 32
) (
  input  wire                   clk,
  input  wire                   rst,
  input  incp_pkg::cmd_t        cmd,
  output incp_pkg::sts_t        sts,
  input  wire  [2:0]            op,
  input  wire  [4:0]            irq,
  input  wire  signed [5:0]     prev_irq,
  input  wire  [63:0]           timestamp,
  output logic signed [5:0]     prev_irq_out,
  output logic [31:0]           active_mask,
  output logic [7:0]            nesting_depth,
  output logic signed [5:0]     current_irq,
  output logic [31:0]           enter_count,
  output logic [63:0]           used_cycles
);
  import incp_pkg::*;

  localparam int ADDR_W = (NUM_IRQ > 1) ? $clog2(NUM_IRQ) : 1;
  localparam logic [5:0] LIMIT = 6'(NUM_IRQ);

  logic [2:0]  op_q;
  logic [4:0]  irq_q;
  logic [5:0]  prev_q;
  logic [5:0]  before_q;
  logic [63:0] now_q;

  logic [31:0] active;
  logic [7:0]  depth;
  logic [5:0]  owner;

  logic [31:0] cnt_mem   [NUM_IRQ];
  logic [63:0] sum_mem   [NUM_IRQ];
  logic [63:0] stamp_mem [NUM_IRQ];
  logic [NUM_IRQ-1:0] cnt_vld, sum_vld, stamp_vld;

  logic [31:0] cnt_q;
  logic [63:0] sum_q, stamp_q;
  logic        cnt_v_q, sum_v_q, stamp_v_q;

  logic [63:0] fwd_sum;
  logic        fwd_hit;
  logic [31:0] res_count;
  logic [63:0] res_used;

  logic              iok, bok, pok, is_enter, is_exit;
  logic [ADDR_W-1:0] iaddr, baddr, paddr, rd_addr, wr_addr;
  logic              we_cnt, we_sum, we_stamp;
  logic [31:0]       wd_cnt, cnt_eff;
  logic [63:0]       wd_sum, sum_eff, stamp_eff, new_sum;

  assign iok      = {1'b0, irq_q} < LIMIT;
  assign bok      = before_q < LIMIT;
  assign pok      = prev_q < LIMIT;
  assign iaddr    = irq_q[ADDR_W-1:0];
  assign baddr    = before_q[ADDR_W-1:0];
  assign paddr    = prev_q[ADDR_W-1:0];
  assign is_enter = (op_q == OP_ENTER);
  assign is_exit  = (op_q == OP_EXIT);

  assign sts.is_enter = is_enter;
  assign sts.is_exit  = is_exit;
  assign sts.prev_ok  = pok;

  assign cnt_eff   = cnt_v_q ? cnt_q : 32'd0;
  assign sum_eff   = sum_v_q ? sum_q : 64'd0;
  assign stamp_eff = stamp_v_q ? stamp_q : 64'd0;
  assign new_sum   = sum_eff + now_q - stamp_eff;
  assign rd_addr   = (cmd.rd_first && is_enter) ? baddr : iaddr;

  always_comb begin
    wr_addr  = iaddr;
    we_cnt   = 1'b0;
    we_sum   = 1'b0;
    we_stamp = 1'b0;
    wd_cnt   = cnt_eff + 32'd1;
    wd_sum   = new_sum;
    if (cmd.upd_a) begin
      if (is_enter) begin
        wr_addr  = baddr;
        we_sum   = bok;
        we_stamp = bok;
      end else if (is_exit) begin
        we_sum   = iok;
        we_stamp = iok;
      end
    end else if (cmd.upd_b) begin
      we_cnt   = iok;
      we_stamp = iok;
    end else if (cmd.stamp) begin
      wr_addr  = paddr;
      we_stamp = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we_cnt) begin
      cnt_mem[wr_addr] <= wd_cnt;
    end
    if (we_sum) begin
      sum_mem[wr_addr] <= wd_sum;
    end
    if (we_stamp) begin
      stamp_mem[wr_addr] <= now_q;
    end
    cnt_q     <= cnt_mem[rd_addr];
    sum_q     <= sum_mem[rd_addr];
    stamp_q   <= stamp_mem[rd_addr];
    cnt_v_q   <= cnt_vld[rd_addr];
    sum_v_q   <= sum_vld[rd_addr];
    stamp_v_q <= stamp_vld[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= '0;
      depth     <= '0;
      owner     <= OWNER_NONE;
      cnt_vld   <= '0;
      sum_vld   <= '0;
      stamp_vld <= '0;
    end else begin
      if (cmd.start) begin
        if (op == OP_ENTER) begin
          active <= active | (32'd1 << irq);
          if (depth < DEPTH_MAX) begin
            depth <= depth + 8'd1;
          end
          owner <= {1'b0, irq};
        end else if (op == OP_EXIT) begin
          active <= active & ~(32'd1 << irq);
          if (depth != 8'd0) begin
            depth <= depth - 8'd1;
          end
          owner <= prev_irq;
        end else if (op == OP_CLEAR) begin
          sum_vld <= '0;
        end else if (op == OP_INIT) begin
          active    <= '0;
          depth     <= '0;
          owner     <= OWNER_NONE;
          cnt_vld   <= '0;
          sum_vld   <= '0;
          stamp_vld <= '0;
        end
      end
      if (we_cnt) begin
        cnt_vld[wr_addr] <= 1'b1;
      end
      if (we_sum) begin
        sum_vld[wr_addr] <= 1'b1;
      end
      if (we_stamp) begin
        stamp_vld[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_q     <= op;
      irq_q    <= irq;
      prev_q   <= prev_irq;
      now_q    <= timestamp;
      before_q <= owner;
    end
    if (cmd.upd_a) begin
      if (is_enter) begin
        fwd_sum <= new_sum;
        fwd_hit <= bok && iok && (baddr == iaddr);
      end else begin
        res_count <= iok ? cnt_eff : 32'd0;
        res_used  <= iok ? (is_exit ? new_sum : sum_eff) : 64'd0;
      end
    end
    if (cmd.upd_b) begin
      res_count <= iok ? wd_cnt : 32'd0;
      res_used  <= iok ? (fwd_hit ? fwd_sum : sum_eff) : 64'd0;
    end
    if (cmd.load) begin
      prev_irq_out  <= before_q;
      active_mask   <= active;
      nesting_depth <= depth;
      current_irq   <= owner;
      enter_count   <= res_count;
      used_cycles   <= res_used;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/interrupt_nesting_cycle_profiler_top.sv]
// ----------------------------------------------------------------------------
// interrupt_nesting_cycle_profiler_top
// Per-interrupt entry counts and cycle usage with nesting tracking.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries one event request: op, irq,
// prev_irq and the cycle timestamp. Output channel (out_valid / out_stall)
// returns one result per request: owner before, active mask, depth, owner
// after, entry count and charged cycles of irq.
// One request is in flight at a time. After acceptance a request passes
// a read state and an update state (read, clear, init, exit restoring no
// owner), plus a second update or a stamp state (enter, exit restoring an
// owner), then loads the result; the next request is taken in the cycle
// after the result is loaded. The sequence is set by the single
// registered-read table port: each table access needs a read step and an
// update step, and enter touches two entries. Reset, or an init request,
// clears nesting state and all table entries at once through per-entry
// valid bits. A stalled result holds in the output register; a finished
// request waits until that register drains, then the block accepts again.
// ----------------------------------------------------------------------------
`default_nettype none

module interrupt_nesting_cycle_profiler_top #(
  parameter int NUM_IRQ = 32
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_stall,
  input  wire  [2:0]        op,
  input  wire  [4:0]        irq,
  input  wire  signed [5:0] prev_irq,
  input  wire  [63:0]       timestamp,
  output logic              out_valid,
  input  wire               out_stall,
  output logic signed [5:0] prev_irq_out,
  output logic [31:0]       active_mask,
  output logic [7:0]        nesting_depth,
  output logic signed [5:0] current_irq,
  output logic [31:0]       enter_count,
  output logic [63:0]       used_cycles
);
  import incp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  incp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  incp_datapath #(
    .NUM_IRQ (NUM_IRQ)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .op            (op),
    .irq           (irq),
    .prev_irq      (prev_irq),
    .timestamp     (timestamp),
    .prev_irq_out  (prev_irq_out),
    .active_mask   (active_mask),
    .nesting_depth (nesting_depth),
    .current_irq   (current_irq),
    .enter_count   (enter_count),
    .used_cycles   (used_cycles)
  );

endmodule

`default_nettype wire
